// File: hdl/irqrr_pkg.sv
// Shared types, sizes and codes of the IRQ redirection router.
`default_nettype none

package irqrr_pkg;

   // Table sizes.
   localparam int OVERRIDE_SLOTS = 24;
   localparam int UNIT_SLOTS     = 8;

   localparam int OVR_IDX_W  = (OVERRIDE_SLOTS > 1) ? $clog2(OVERRIDE_SLOTS) : 1;
   localparam int OVR_CNT_W  = $clog2(OVERRIDE_SLOTS + 1);
   localparam int UNIT_IDX_W = (UNIT_SLOTS > 1) ? $clog2(UNIT_SLOTS) : 1;
   localparam int UNIT_CNT_W = $clog2(UNIT_SLOTS + 1);
   localparam int SCAN_W     = (OVR_CNT_W > UNIT_CNT_W) ? OVR_CNT_W : UNIT_CNT_W;

   // Redirection entry layout.
   localparam logic [7:0] REDTBL_FIRST = 8'h10;
   localparam logic [1:0] MPS_FLAG_SET = 2'h3;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_DEST_CPU = 1'b0;

   typedef enum logic [1:0] {
      OP_LOAD_OVERRIDE = 2'd0,
      OP_LOAD_UNIT     = 2'd1,
      OP_RESOLVE       = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  irq_number;
      logic [31:0] gsi_value;
      logic [15:0] override_flags;
      logic [8:0]  entry_count;
      logic [7:0]  vector_number;
      logic        mask_request;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  unit_index;
      logic [7:0]  redirect_register;
      logic [63:0] entry_value;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_override;
      logic load_unit;
      logic start;
      logic ovr_next;
      logic ovr_take;
      logic scan_reset;
      logic unit_next;
      logic unit_take;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ovr_end;
      logic ovr_hit;
      logic unit_end;
      logic unit_hit;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: hdl/irqrr_ctrl.sv
// Controller of the IRQ redirection router: sequences loads and the two table scans.
`default_nettype none

module irqrr_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic [1:0]            req_opcode,
   output logic                       req_stall,
   input  wire irqrr_pkg::status_type status,
   output irqrr_pkg::cmd_type         cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_OVR_SCAN,
      S_UNIT_SCAN,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  irqrr_pkg::OP_LOAD_OVERRIDE: cmd.load_override = 1'b1;
                  irqrr_pkg::OP_LOAD_UNIT:     cmd.load_unit = 1'b1;
                  irqrr_pkg::OP_RESOLVE: begin
                     cmd.start = 1'b1;
                     state_in  = S_OVR_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         S_OVR_SCAN: begin
            if (status.ovr_end) begin
               cmd.scan_reset = 1'b1;
               state_in       = S_UNIT_SCAN;
            end else if (status.ovr_hit) begin
               cmd.ovr_take = 1'b1;
               state_in     = S_UNIT_SCAN;
            end else begin
               cmd.ovr_next = 1'b1;
            end
         end
         S_UNIT_SCAN: begin
            if (status.unit_end) begin
               state_in = S_EMIT;
            end else if (status.unit_hit) begin
               cmd.unit_take = 1'b1;
               state_in      = S_EMIT;
            end else begin
               cmd.unit_next = 1'b1;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/irqrr_dp.sv
// Datapath of the IRQ redirection router: both tables, scan registers and the result register.
`default_nettype none

module irqrr_dp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire irqrr_pkg::req_payload_type req_payload,
   input  wire logic [7:0]                 dest_cpu,
   input  wire irqrr_pkg::cmd_type         cmd,
   output irqrr_pkg::status_type           status,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output irqrr_pkg::rsp_payload_type      rsp_payload
);

   // Override table.
   logic [7:0]  ovr_source_ff [irqrr_pkg::OVERRIDE_SLOTS];
   logic [31:0] ovr_target_ff [irqrr_pkg::OVERRIDE_SLOTS];
   logic        ovr_low_ff    [irqrr_pkg::OVERRIDE_SLOTS];
   logic        ovr_level_ff  [irqrr_pkg::OVERRIDE_SLOTS];
   logic [irqrr_pkg::OVR_CNT_W-1:0] ovr_used_ff;
   logic [irqrr_pkg::OVR_CNT_W-1:0] ovr_used_in;

   // I/O APIC range table.
   logic [31:0] unit_base_ff [irqrr_pkg::UNIT_SLOTS];
   logic [8:0]  unit_span_ff [irqrr_pkg::UNIT_SLOTS];
   logic [irqrr_pkg::UNIT_CNT_W-1:0] unit_used_ff;
   logic [irqrr_pkg::UNIT_CNT_W-1:0] unit_used_in;

   // Working registers of one resolve.
   logic [irqrr_pkg::SCAN_W-1:0]     idx_ff;
   logic [7:0]                       irq_ff;
   logic [7:0]                       vec_ff;
   logic                             mask_ff;
   logic [31:0]                      gsi_ff;
   logic                             low_ff;
   logic                             level_ff;
   logic                             found_ff;
   logic [irqrr_pkg::UNIT_IDX_W-1:0] unit_ff;
   logic [7:0]                       slot_ff;

   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   irqrr_pkg::rsp_payload_type       rsp_payload_ff;
   irqrr_pkg::rsp_payload_type       rsp_payload_in;

   logic                             ovr_full;
   logic                             unit_full;
   logic [irqrr_pkg::OVR_IDX_W-1:0]  ovr_rd;
   logic [irqrr_pkg::UNIT_IDX_W-1:0] unit_rd;
   logic [irqrr_pkg::OVR_IDX_W-1:0]  ovr_wr;
   logic [irqrr_pkg::UNIT_IDX_W-1:0] unit_wr;
   logic [32:0]                      range_hi;
   logic [7:0]                       slot_sel;

   assign ovr_full  = (ovr_used_ff == irqrr_pkg::OVR_CNT_W'(irqrr_pkg::OVERRIDE_SLOTS));
   assign unit_full = (unit_used_ff == irqrr_pkg::UNIT_CNT_W'(irqrr_pkg::UNIT_SLOTS));
   assign ovr_rd    = idx_ff[irqrr_pkg::OVR_IDX_W-1:0];
   assign unit_rd   = idx_ff[irqrr_pkg::UNIT_IDX_W-1:0];
   assign ovr_wr    = ovr_used_ff[irqrr_pkg::OVR_IDX_W-1:0];
   assign unit_wr   = unit_used_ff[irqrr_pkg::UNIT_IDX_W-1:0];

   assign ovr_used_in  = (cmd.load_override && !ovr_full)
                         ? ovr_used_ff + 1'b1 : ovr_used_ff;
   assign unit_used_in = (cmd.load_unit && !unit_full)
                         ? unit_used_ff + 1'b1 : unit_used_ff;

   // The upper range bound is formed at 33 bits so that it never wraps.
   assign range_hi = {1'b0, unit_base_ff[unit_rd]} + 33'(unit_span_ff[unit_rd]);

   always_comb begin
      status.ovr_end  = (idx_ff >= irqrr_pkg::SCAN_W'(ovr_used_ff));
      status.ovr_hit  = (ovr_source_ff[ovr_rd] == irq_ff);
      status.unit_end = (idx_ff >= irqrr_pkg::SCAN_W'(unit_used_ff));
      status.unit_hit = (gsi_ff >= unit_base_ff[unit_rd]) && ({1'b0, gsi_ff} < range_hi);
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   // Without an owning unit the entry index is the low byte of the GSI itself.
   assign slot_sel = found_ff ? slot_ff : gsi_ff[7:0];

   always_comb begin
      rsp_payload_in                   = rsp_payload_ff;
      rsp_valid_in                     = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in                     = 1'b1;
         rsp_payload_in.unit_index        = found_ff ? 3'(unit_ff) : 3'd0;
         rsp_payload_in.redirect_register = irqrr_pkg::REDTBL_FIRST + {slot_sel[6:0], 1'b0};
         rsp_payload_in.entry_value       = {dest_cpu, 39'd0, mask_ff, level_ff, 1'b0,
                                             low_ff, 5'd0, vec_ff};
      end
   end

   // Table storage: written only at the fill count while not full, never cleared.
   always_ff @(posedge clock) begin
      if (cmd.load_override && !ovr_full) begin
         ovr_source_ff[ovr_wr] <= req_payload.irq_number;
         ovr_target_ff[ovr_wr] <= req_payload.gsi_value;
         ovr_low_ff[ovr_wr]    <= (req_payload.override_flags[1:0] == irqrr_pkg::MPS_FLAG_SET);
         ovr_level_ff[ovr_wr]  <= (req_payload.override_flags[3:2] == irqrr_pkg::MPS_FLAG_SET);
      end
      if (cmd.load_unit && !unit_full) begin
         unit_base_ff[unit_wr] <= req_payload.gsi_value;
         unit_span_ff[unit_wr] <= req_payload.entry_count;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         irq_ff   <= req_payload.irq_number;
         vec_ff   <= req_payload.vector_number;
         mask_ff  <= req_payload.mask_request;
         gsi_ff   <= 32'(req_payload.irq_number);
         low_ff   <= 1'b0;
         level_ff <= 1'b0;
         found_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (cmd.ovr_take) begin
         gsi_ff   <= ovr_target_ff[ovr_rd];
         low_ff   <= ovr_low_ff[ovr_rd];
         level_ff <= ovr_level_ff[ovr_rd];
         idx_ff   <= '0;
      end else if (cmd.scan_reset) begin
         idx_ff <= '0;
      end else if (cmd.ovr_next || cmd.unit_next) begin
         idx_ff <= idx_ff + 1'b1;
      end else if (cmd.unit_take) begin
         found_ff <= 1'b1;
         unit_ff  <= unit_rd;
         slot_ff  <= gsi_ff[7:0] - unit_base_ff[unit_rd][7:0];
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovr_used_ff  <= '0;
         unit_used_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ovr_used_ff  <= ovr_used_in;
         unit_used_ff <= unit_used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_ovr_bound: assert property (@(posedge clock) disable iff (reset)
      ovr_used_ff <= irqrr_pkg::OVR_CNT_W'(irqrr_pkg::OVERRIDE_SLOTS))
      else $error("override fill count beyond table size");

   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      unit_used_ff <= irqrr_pkg::UNIT_CNT_W'(irqrr_pkg::UNIT_SLOTS))
      else $error("unit fill count beyond table size");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result written over an item not yet taken");

   a_take_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.ovr_take || cmd.unit_take) |-> (idx_ff < irqrr_pkg::SCAN_W'(
         cmd.ovr_take ? irqrr_pkg::SCAN_W'(ovr_used_ff) : irqrr_pkg::SCAN_W'(unit_used_ff))))
      else $error("table match taken from an unfilled entry");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted item not shown on the result channel");
`endif

endmodule

`default_nettype wire

// File: hdl/irq_redirection_router_core.sv
// Top level of the IRQ redirection router: configuration register, controller and datapath.
//
//   channel   ports                               direction
//   req       req_valid, req_stall, req_payload   items in (loads and resolves)
//   rsp       rsp_valid, rsp_stall, rsp_payload   one result item per resolve
//   csr       psel, penable, pwrite, paddr, ...   destination CPU id register
//
// A load is taken while the controller is idle. A resolve walks the override table and then
// the range table one entry a cycle with the single scan index, and then waits to emit its
// result until the output register is free.
// Reset is synchronous; it clears the fill counts, controller, result valid and dest CPU id.
// A finished result waits in the output register, and new items are taken meanwhile;
// only a second resolve waits for that register to drain.
`default_nettype none

module irq_redirection_router_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire irqrr_pkg::req_payload_type          req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output irqrr_pkg::rsp_payload_type               rsp_payload,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [irqrr_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [irqrr_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [irqrr_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                     pready
);

   logic [7:0]            dest_cpu_ff;
   logic [7:0]            dest_cpu_in;
   logic                  csr_write;
   irqrr_pkg::cmd_type    cmd;
   irqrr_pkg::status_type status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[2] == irqrr_pkg::REG_DEST_CPU);
   assign dest_cpu_in = csr_write ? pwdata[7:0] : dest_cpu_ff;
   assign prdata = (paddr[2] == irqrr_pkg::REG_DEST_CPU)
                   ? irqrr_pkg::CSR_DATA_W'(dest_cpu_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_cpu_ff <= '0;
      end else begin
         dest_cpu_ff <= dest_cpu_in;
      end
   end

   irqrr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_payload.opcode),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   irqrr_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .dest_cpu    (dest_cpu_ff),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
